[rtl/adsr_envelope_generator_unit_defines.svh]
// ----------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// assertion on a named clock and active-low reset
`define ADSR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion on the block clock and reset
`define ADSR_ASSERT(label, prop, msg) `ADSR_ASSERT_CLK(label, clk, arst_n, prop, msg)
`else
`define ADSR_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ADSR_ASSERT(label, prop, msg)
`endif
`endif

[rtl/adsr_pkg.sv]
// ----------------------------------------------------------------------------
// ADSR envelope generator package
// Stage codes, register indexes, widths and the control bundle type.
// ----------------------------------------------------------------------------
package adsr_pkg;

	localparam int LEVEL_W    = 16;
	localparam int INC_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// envelope stage codes
	typedef enum logic [2:0] {
		ST_REST    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_INC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_INC   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_INC = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN     = 2'd3;

	// stage and start levels after this tick's update
	typedef struct packed {
		stage_t             stage;
		logic [LEVEL_W-1:0] attack_start;
		logic [LEVEL_W-1:0] release_start;
	} adsr_ctrl_t;

endpackage

[rtl/adsr_tick_if.sv]
// ----------------------------------------------------------------------------
// ADSR tick channel
// One sample tick per transfer: gate and trigger levels.
// ----------------------------------------------------------------------------
interface adsr_tick_if;
	logic valid;
	logic ready;
	logic gate_level;
	logic trigger_level;

	modport source (output valid, output gate_level, output trigger_level, input ready);
	modport sink (input valid, input gate_level, input trigger_level, output ready);
endinterface

[rtl/adsr_env_if.sv]
// ----------------------------------------------------------------------------
// ADSR envelope channel
// One envelope level and stage code per transfer.
// ----------------------------------------------------------------------------
interface adsr_env_if;
	logic        valid;
	logic        ready;
	logic [15:0] envelope_level;
	logic [2:0]  stage;

	modport source (output valid, output envelope_level, output stage, input ready);
	modport sink (input valid, input envelope_level, input stage, output ready);
endinterface

[rtl/adsr_curve_rom.sv]
// ----------------------------------------------------------------------------
// ADSR curve ROM
// Rising attack and falling decay curves, built at elaboration from their
// recurrences and read combinationally at one index.
// ----------------------------------------------------------------------------
module adsr_curve_rom #(
	parameter int CURVE_LENGTH = 256
) (
	input  logic [$clog2(CURVE_LENGTH)-1:0] idx,
	output logic [adsr_pkg::LEVEL_W-1:0]    attack_val,
	output logic [adsr_pkg::LEVEL_W-1:0]    decay_val
);

	// recurrence constants, 32 fraction bits
	localparam logic [63:0] Q32_ONE    = 64'd4294967296;
	localparam logic [63:0] ATK_TARGET = 64'd5583457485;
	localparam logic [63:0] ATK_FACTOR = 64'd24481314;
	localparam logic [63:0] DEC_FACTOR = 64'd128849019;
	localparam logic [63:0] HALF_Q32   = 64'd2147483648;

	typedef logic [CURVE_LENGTH-1:0][adsr_pkg::LEVEL_W-1:0] curve_tbl_t;

	// round a Q32 value to Q0.16 with saturation
	function automatic logic [adsr_pkg::LEVEL_W-1:0] to_q16(input logic [63:0] v);
		logic [63:0] r;
		r = (v + 64'd32768) >> 16;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic curve_tbl_t build_curve(input logic decay_sel);
		logic [63:0] a;
		logic [63:0] d;
		logic [63:0] da;
		logic [63:0] dd;
		curve_tbl_t  tbl;
		a = '0;
		d = '0;
		for (int i = 0; i < CURVE_LENGTH; i++) begin
			if (i > 0) begin
				da = (a < ATK_TARGET) ? ATK_TARGET - a : 64'd0;
				dd = (d < Q32_ONE) ? Q32_ONE - d : 64'd0;
				a  = a + ((da * ATK_FACTOR + HALF_Q32) >> 32);
				d  = d + ((dd * DEC_FACTOR + HALF_Q32) >> 32);
			end
			tbl[i] = decay_sel ? to_q16((d < Q32_ONE) ? Q32_ONE - d : 64'd0) : to_q16(a);
		end
		return tbl;
	endfunction

	localparam curve_tbl_t ATTACK_TBL = build_curve(1'b0);
	localparam curve_tbl_t DECAY_TBL  = build_curve(1'b1);

	// table lookup
	assign attack_val = ATTACK_TBL[idx];
	assign decay_val  = DECAY_TBL[idx];

endmodule

[rtl/adsr_stage_ctrl.sv]
// ----------------------------------------------------------------------------
// ADSR stage control
// Edge detection, stage sequencing and the phase accumulator. The next state
// and curve index come out combinationally; state registers load on a fire.
// ----------------------------------------------------------------------------
module adsr_stage_ctrl #(
	parameter int CURVE_LENGTH = 256,
	parameter int PHASE_WIDTH  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic                              gate_level,
	input  logic                              trigger_level,
	input  logic [adsr_pkg::INC_W-1:0]        attack_inc,
	input  logic [adsr_pkg::INC_W-1:0]        decay_inc,
	input  logic [adsr_pkg::INC_W-1:0]        release_inc,
	input  logic [adsr_pkg::LEVEL_W-1:0]      level,
	output adsr_pkg::adsr_ctrl_t              ctrl,
	output logic [$clog2(CURVE_LENGTH)-1:0]   idx
);

	localparam int IDX_W  = $clog2(CURVE_LENGTH);
	localparam int SUM_W  = ((PHASE_WIDTH > adsr_pkg::INC_W) ? PHASE_WIDTH : adsr_pkg::INC_W) + 1;
	localparam int PROD_W = PHASE_WIDTH + IDX_W + 1;
	localparam logic [PROD_W-1:0] LEN = PROD_W'(CURVE_LENGTH);

	adsr_pkg::stage_t             stage_q;
	logic [PHASE_WIDTH-1:0]       phase_q;
	logic                         gate_prev_q;
	logic                         trig_prev_q;
	logic [adsr_pkg::LEVEL_W-1:0] attack_start_q;
	logic [adsr_pkg::LEVEL_W-1:0] release_start_q;
	logic [adsr_pkg::LEVEL_W-1:0] last_level_q;

	logic                         rise;
	logic                         fall;
	adsr_pkg::stage_t             stg;
	adsr_pkg::stage_t             stg_n;
	logic [PHASE_WIDTH-1:0]       ph;
	logic [PHASE_WIDTH-1:0]       ph_n;
	logic [adsr_pkg::LEVEL_W-1:0] as;
	logic [adsr_pkg::LEVEL_W-1:0] rs;
	logic [adsr_pkg::INC_W-1:0]   inc;
	logic                         running;
	logic [SUM_W-1:0]             sum;
	logic                         carry;
	logic [PROD_W-1:0]            prod;

	// edges, stage sequencing and phase step
	always_comb begin
		rise = (gate_level && !gate_prev_q) || (trigger_level && !trig_prev_q);
		fall = !gate_level && gate_prev_q;
		stg  = stage_q;
		ph   = phase_q;
		as   = attack_start_q;
		rs   = release_start_q;
		if (rise && stage_q != adsr_pkg::ST_ATTACK) begin
			as  = last_level_q;
			ph  = '0;
			stg = adsr_pkg::ST_ATTACK;
		end
		// gate fall wins over a rise in the same tick
		if (fall) begin
			rs  = last_level_q;
			ph  = '0;
			stg = adsr_pkg::ST_RELEASE;
		end

		case (stg)
			adsr_pkg::ST_ATTACK: begin
				inc     = attack_inc;
				running = 1'b1;
			end
			adsr_pkg::ST_DECAY: begin
				inc     = decay_inc;
				running = 1'b1;
			end
			adsr_pkg::ST_RELEASE: begin
				inc     = release_inc;
				running = 1'b1;
			end
			default: begin
				inc     = '0;
				running = 1'b0;
			end
		endcase

		sum   = SUM_W'(ph) + SUM_W'(inc);
		carry = |sum[SUM_W-1:PHASE_WIDTH];
		ph_n  = ph;
		stg_n = stg;
		if (running) begin
			if (carry) begin
				// wrap drops the remainder and advances the stage
				ph_n = '0;
				case (stg)
					adsr_pkg::ST_ATTACK: stg_n = adsr_pkg::ST_DECAY;
					adsr_pkg::ST_DECAY:  stg_n = adsr_pkg::ST_SUSTAIN;
					default:             stg_n = adsr_pkg::ST_REST;
				endcase
			end else begin
				ph_n = sum[PHASE_WIDTH-1:0];
			end
		end

		// curve index from the top of the phase
		prod = PROD_W'(ph_n) * LEN;
	end

	assign idx                = prod[PHASE_WIDTH+IDX_W-1:PHASE_WIDTH];
	assign ctrl.stage         = stg_n;
	assign ctrl.attack_start  = as;
	assign ctrl.release_start = rs;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q         <= adsr_pkg::ST_REST;
			phase_q         <= '0;
			gate_prev_q     <= 1'b0;
			trig_prev_q     <= 1'b0;
			attack_start_q  <= '0;
			release_start_q <= '0;
			last_level_q    <= '0;
		end else if (fire) begin
			stage_q         <= stg_n;
			phase_q         <= ph_n;
			gate_prev_q     <= gate_level;
			trig_prev_q     <= trigger_level;
			attack_start_q  <= as;
			release_start_q <= rs;
			last_level_q    <= level;
		end
	end

endmodule

[rtl/adsr_level_calc.sv]
// ----------------------------------------------------------------------------
// ADSR level calculation
// Curve lookup and one shared multiply-add that blends the curve between
// the stage's start and end levels, saturated to Q0.16.
// ----------------------------------------------------------------------------
module adsr_level_calc #(
	parameter int CURVE_LENGTH = 256
) (
	input  adsr_pkg::adsr_ctrl_t              ctrl,
	input  logic [$clog2(CURVE_LENGTH)-1:0]   idx,
	input  logic [adsr_pkg::LEVEL_W-1:0]      sustain,
	output logic [adsr_pkg::LEVEL_W-1:0]      level
);

	logic [adsr_pkg::LEVEL_W-1:0] attack_val;
	logic [adsr_pkg::LEVEL_W-1:0] decay_val;
	logic [16:0]                  ma;
	logic [15:0]                  mb;
	logic [15:0]                  base;
	logic [32:0]                  prod;
	logic [33:0]                  rnd;
	logic [18:0]                  total;

	adsr_curve_rom #(
		.CURVE_LENGTH(CURVE_LENGTH)
	) u_rom (
		.idx       (idx),
		.attack_val(attack_val),
		.decay_val (decay_val)
	);

	// operand selection per stage
	always_comb begin
		case (ctrl.stage)
			adsr_pkg::ST_ATTACK: begin
				ma   = 17'h1_0000 - {1'b0, ctrl.attack_start};
				mb   = attack_val;
				base = ctrl.attack_start;
			end
			adsr_pkg::ST_DECAY: begin
				ma   = 17'h1_0000 - {1'b0, sustain};
				mb   = decay_val;
				base = sustain;
			end
			adsr_pkg::ST_SUSTAIN: begin
				ma   = '0;
				mb   = '0;
				base = sustain;
			end
			adsr_pkg::ST_RELEASE: begin
				ma   = {1'b0, ctrl.release_start};
				mb   = decay_val;
				base = '0;
			end
			default: begin
				ma   = '0;
				mb   = '0;
				base = '0;
			end
		endcase
	end

	// multiply, round, add and saturate
	assign prod  = 33'(ma) * 33'(mb);
	assign rnd   = 34'(prod) + 34'd32768;
	assign total = 19'(rnd[33:16]) + 19'(base);
	assign level = (|total[18:16]) ? 16'hFFFF : total[15:0];

endmodule

[rtl/adsr_envelope_generator_unit.sv]
// ----------------------------------------------------------------------------
// ADSR envelope generator unit
// A tick transfer loads the input register; its result is registered on fire.
// Throughput: one tick per cycle unless envelope.ready stalls; the stage update,
// curve ROM read and single 17x16 multiply-add sit between the input and result registers.
// Reset: arst_n clears stage, phase, edge history, start levels and valid flags, and loads configuration defaults.
// ----------------------------------------------------------------------------
`include "adsr_envelope_generator_unit_defines.svh"

module adsr_envelope_generator_unit #(
	parameter int CURVE_LENGTH = 256,
	parameter int PHASE_WIDTH  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	adsr_tick_if.sink                           tick,
	adsr_env_if.source                          envelope,
	input  logic                                cfg_we,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [adsr_pkg::INC_W-1:0]   attack_inc_q;
	logic [adsr_pkg::INC_W-1:0]   decay_inc_q;
	logic [adsr_pkg::INC_W-1:0]   release_inc_q;
	logic [adsr_pkg::LEVEL_W-1:0] sustain_q;

	logic                         valid_s1;
	logic                         gate_s1;
	logic                         trig_s1;
	logic                         env_valid_q;
	logic [adsr_pkg::LEVEL_W-1:0] env_level_q;
	adsr_pkg::stage_t             env_stage_q;

	logic                         advance;
	logic                         fire;
	adsr_pkg::adsr_ctrl_t         ctrl;
	logic [$clog2(CURVE_LENGTH)-1:0] idx;
	logic [adsr_pkg::LEVEL_W-1:0] level;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_inc_q  <= 32'd89478;
			decay_inc_q   <= 32'd89478;
			release_inc_q <= 32'd89478;
			sustain_q     <= 16'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				adsr_pkg::CFG_ATTACK_INC:  attack_inc_q  <= cfg_data;
				adsr_pkg::CFG_DECAY_INC:   decay_inc_q   <= cfg_data;
				adsr_pkg::CFG_RELEASE_INC: release_inc_q <= cfg_data;
				adsr_pkg::CFG_SUSTAIN:     sustain_q     <= cfg_data[adsr_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control: result register frees the input stage
	assign advance    = !env_valid_q || envelope.ready;
	assign fire       = valid_s1 && advance;
	assign tick.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.valid && tick.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			gate_s1 <= tick.gate_level;
			trig_s1 <= tick.trigger_level;
		end
	end

	adsr_stage_ctrl #(
		.CURVE_LENGTH(CURVE_LENGTH),
		.PHASE_WIDTH (PHASE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.gate_level   (gate_s1),
		.trigger_level(trig_s1),
		.attack_inc   (attack_inc_q),
		.decay_inc    (decay_inc_q),
		.release_inc  (release_inc_q),
		.level        (level),
		.ctrl         (ctrl),
		.idx          (idx)
	);

	adsr_level_calc #(
		.CURVE_LENGTH(CURVE_LENGTH)
	) u_level (
		.ctrl   (ctrl),
		.idx    (idx),
		.sustain(sustain_q),
		.level  (level)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_valid_q <= 1'b0;
		end else if (advance) begin
			env_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			env_level_q <= level;
			env_stage_q <= ctrl.stage;
		end
	end

	assign envelope.valid          = env_valid_q;
	assign envelope.envelope_level = env_level_q;
	assign envelope.stage          = env_stage_q;

	// checks
	`ADSR_ASSERT(a_sustain_out, envelope.valid && envelope.stage == adsr_pkg::ST_SUSTAIN |-> envelope.envelope_level == sustain_q, "sustain result differs from sustain level")
	`ADSR_ASSERT(a_rest_out, envelope.valid && envelope.stage == adsr_pkg::ST_REST |-> envelope.envelope_level == 16'd0, "rest result is not zero")
	`ADSR_ASSERT(a_s1_hold, valid_s1 && !advance |=> valid_s1 && $stable(gate_s1) && $stable(trig_s1), "input stage lost while stalled")
	`ADSR_ASSERT(a_fire_result, fire |=> env_valid_q, "fired tick gave no result")

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Streams gate/trigger ticks through the envelope unit under several register
// settings and random handshake pressure, and checks every level and stage
// against a cycle-free model of the envelope kept in this file.
// ----------------------------------------------------------------------------
module tb;

	localparam int CURVE_LEN   = 256;
	localparam int PHASE_W     = 32;
	localparam int NUM_PHASES  = 6;
	localparam int PHASE_TICKS = 290;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [63:0] Q32_ONE    = 64'd4294967296;
	localparam logic [63:0] RISE_TGT   = 64'd5583457485;
	localparam logic [63:0] RISE_COEF  = 64'd24481314;
	localparam logic [63:0] FALL_COEF  = 64'd128849019;
	localparam logic [63:0] HALF_Q32   = 64'd2147483648;

	typedef struct packed {
		logic gate;
		logic trig;
	} tick_item_t;

	typedef struct packed {
		logic [adsr_pkg::LEVEL_W-1:0] level;
		adsr_pkg::stage_t             stage;
	} env_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	adsr_tick_if tick_ch ();
	adsr_env_if env_ch ();

	adsr_envelope_generator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.envelope  (env_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadows
	logic [adsr_pkg::INC_W-1:0]   attack_inc;
	logic [adsr_pkg::INC_W-1:0]   decay_inc;
	logic [adsr_pkg::INC_W-1:0]   release_inc;
	logic [adsr_pkg::LEVEL_W-1:0] sustain_lvl;

	// envelope state
	adsr_pkg::stage_t             env_stage;
	logic [PHASE_W-1:0]           env_phase;
	logic                         gate_prev;
	logic                         trig_prev;
	logic [adsr_pkg::LEVEL_W-1:0] atk_start;
	logic [adsr_pkg::LEVEL_W-1:0] rel_start;
	logic [adsr_pkg::LEVEL_W-1:0] last_out;
	logic [adsr_pkg::LEVEL_W-1:0] rise_curve [CURVE_LEN];
	logic [adsr_pkg::LEVEL_W-1:0] fall_curve [CURVE_LEN];

	tick_item_t  pending_ticks [$];
	env_result_t expected_env [$];

	int ticks_offered = 0;
	int ticks_accepted = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int rx_hold_left = 0;
	int hold_requests = 0;
	int hold_served = 0;

	always #5 clk = ~clk;

	function automatic logic [adsr_pkg::LEVEL_W-1:0] round_to_q16(logic [63:0] v);
		logic [63:0] r;
		r = (v + 64'd32768) >> 16;
		return (r > 64'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	// fixed rising and falling shapes, Q32 recurrences rounded to Q0.16
	function automatic void build_shape_tables();
		logic [63:0] a, d, da, dd;
		a = '0;
		d = '0;
		for (int i = 0; i < CURVE_LEN; i++) begin
			if (i > 0) begin
				da = (a < RISE_TGT) ? RISE_TGT - a : 64'd0;
				dd = (d < Q32_ONE) ? Q32_ONE - d : 64'd0;
				a = a + ((da * RISE_COEF + HALF_Q32) >> 32);
				d = d + ((dd * FALL_COEF + HALF_Q32) >> 32);
			end
			rise_curve[i] = round_to_q16(a);
			fall_curve[i] = round_to_q16((d < Q32_ONE) ? Q32_ONE - d : 64'd0);
		end
	endfunction

	// one sample tick: edges, phase step, then level
	function automatic env_result_t step_envelope(logic g, logic t);
		logic [PHASE_W:0]           sum;
		logic [adsr_pkg::INC_W-1:0] inc;
		logic                       running;
		logic [63:0]                idx;
		logic [63:0]                acc;
		env_result_t                res;
		if ((g && !gate_prev) || (t && !trig_prev)) begin
			if (env_stage != adsr_pkg::ST_ATTACK) begin
				atk_start = last_out;
				env_phase = '0;
				env_stage = adsr_pkg::ST_ATTACK;
			end
		end
		if (!g && gate_prev) begin
			rel_start = last_out;
			env_phase = '0;
			env_stage = adsr_pkg::ST_RELEASE;
		end
		gate_prev = g;
		trig_prev = t;

		running = 1'b1;
		inc = '0;
		case (env_stage)
			adsr_pkg::ST_ATTACK:  inc = attack_inc;
			adsr_pkg::ST_DECAY:   inc = decay_inc;
			adsr_pkg::ST_RELEASE: inc = release_inc;
			default:              running = 1'b0;
		endcase
		if (running) begin
			sum = {1'b0, env_phase} + {1'b0, inc};
			if (sum[PHASE_W]) begin
				// carry drops the remainder and moves to the next stage
				env_phase = '0;
				case (env_stage)
					adsr_pkg::ST_ATTACK: env_stage = adsr_pkg::ST_DECAY;
					adsr_pkg::ST_DECAY:  env_stage = adsr_pkg::ST_SUSTAIN;
					default:             env_stage = adsr_pkg::ST_REST;
				endcase
			end else begin
				env_phase = sum[PHASE_W-1:0];
			end
		end

		idx = (64'(env_phase) * 64'(CURVE_LEN)) >> PHASE_W;
		if (idx >= 64'(CURVE_LEN))
			idx = 64'(CURVE_LEN - 1);
		case (env_stage)
			adsr_pkg::ST_ATTACK: begin
				acc = ((64'd65536 - 64'(atk_start)) * 64'(rise_curve[idx]) + 64'd32768) >> 16;
				acc = acc + 64'(atk_start);
			end
			adsr_pkg::ST_DECAY: begin
				acc = ((64'd65536 - 64'(sustain_lvl)) * 64'(fall_curve[idx]) + 64'd32768) >> 16;
				acc = acc + 64'(sustain_lvl);
			end
			adsr_pkg::ST_SUSTAIN: acc = 64'(sustain_lvl);
			adsr_pkg::ST_RELEASE: acc = (64'(rel_start) * 64'(fall_curve[idx]) + 64'd32768) >> 16;
			default:              acc = '0;
		endcase
		last_out = (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
		res.level = last_out;
		res.stage = env_stage;
		return res;
	endfunction

	function automatic void push_tick(logic g, logic t);
		tick_item_t it;
		it.gate = g;
		it.trig = t;
		pending_ticks.push_back(it);
	endfunction

	// mostly whole notes (gate held then released), the rest noise bursts
	function automatic void queue_random_ticks(int count);
		int added;
		int len;
		added = 0;
		while (added < count) begin
			if ($urandom_range(99) < 85) begin
				len = $urandom_range(60, 1);
				for (int k = 0; k < len; k++)
					push_tick(1'b1, $urandom_range(99) < 8);
				added += len;
				len = $urandom_range(60, 1);
				for (int k = 0; k < len; k++)
					push_tick(1'b0, $urandom_range(99) < 5);
				added += len;
			end else begin
				len = $urandom_range(6, 1);
				for (int k = 0; k < len; k++)
					push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
				added += len;
			end
		end
	endfunction

	function automatic logic [adsr_pkg::INC_W-1:0] rand_inc();
		if ($urandom_range(7) == 0)
			return $urandom_range(32'hFFFF_FFFF, 1);
		return $urandom_range(32'hFFFF_FFFF, 32'h0800_0000);
	endfunction

	task automatic write_reg(input logic [adsr_pkg::CFG_IDX_W-1:0] idx,
			input logic [adsr_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			adsr_pkg::CFG_ATTACK_INC:  attack_inc = val;
			adsr_pkg::CFG_DECAY_INC:   decay_inc = val;
			adsr_pkg::CFG_RELEASE_INC: release_inc = val;
			adsr_pkg::CFG_SUSTAIN:     sustain_lvl = val[adsr_pkg::LEVEL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// tick driver: holds the current item until its transfer
	always @(negedge clk) begin
		tick_item_t nxt;
		if (arst_n && ticks_accepted == ticks_offered) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_ticks.pop_front();
				tick_ch.valid <= 1'b1;
				tick_ch.gate_level <= nxt.gate;
				tick_ch.trigger_level <= nxt.trig;
				ticks_offered++;
			end else begin
				tick_ch.valid <= 1'b0;
				tick_ch.gate_level <= 1'($urandom_range(1));
				tick_ch.trigger_level <= 1'($urandom_range(1));
			end
		end
	end

	// result receiver: random stalls plus the long hold-off
	always @(negedge clk) begin
		env_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// hold-off counter, started on each request
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			rx_hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	// monitor: predict on tick transfers, check on envelope transfers
	always @(posedge clk) begin
		env_result_t exp_res;
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready) begin
				ticks_accepted++;
				expected_env.push_back(step_envelope(tick_ch.gate_level, tick_ch.trigger_level));
			end
			if (env_ch.valid && env_ch.ready) begin
				if (expected_env.size() == 0) begin
					$error("envelope transfer with no tick pending");
					fail_count++;
				end else begin
					exp_res = expected_env.pop_front();
					if (env_ch.envelope_level !== exp_res.level) begin
						$error("envelope_level: expected %0d, got %0d",
							exp_res.level, env_ch.envelope_level);
						fail_count++;
					end
					if (env_ch.stage !== exp_res.stage) begin
						$error("stage: expected %0d, got %0d", exp_res.stage, env_ch.stage);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.gate_level = 1'b0;
		tick_ch.trigger_level = 1'b0;
		env_ch.ready = 1'b0;

		attack_inc = 32'd89478;
		decay_inc = 32'd89478;
		release_inc = 32'd89478;
		sustain_lvl = 16'd32768;
		env_stage = adsr_pkg::ST_REST;
		env_phase = '0;
		gate_prev = 1'b0;
		trig_prev = 1'b0;
		atk_start = '0;
		rel_start = '0;
		last_out = '0;
		build_shape_tables();

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// registers only change with nothing in flight
			while (pending_ticks.size() != 0 || ticks_accepted != ticks_offered
					|| expected_env.size() != 0)
				@(negedge clk);

			if (ph < 2) begin
				send_idle_pct = 23;
				recv_idle_pct = 79;
			end else if (ph < 4) begin
				send_idle_pct = 79;
				recv_idle_pct = 23;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			case (ph)
				0: begin
					// four ticks per stage; upper sustain bits are masked off
					write_reg(adsr_pkg::CFG_ATTACK_INC, 32'h4000_0000);
					write_reg(adsr_pkg::CFG_DECAY_INC, 32'h4000_0000);
					write_reg(adsr_pkg::CFG_RELEASE_INC, 32'h4000_0000);
					write_reg(adsr_pkg::CFG_SUSTAIN, 32'hABCD_C000);
				end
				1: begin
					write_reg(adsr_pkg::CFG_ATTACK_INC, 32'hFFFF_FFFF);
					write_reg(adsr_pkg::CFG_DECAY_INC, 32'h0800_0000);
					write_reg(adsr_pkg::CFG_RELEASE_INC, 32'h1000_0000);
					write_reg(adsr_pkg::CFG_SUSTAIN, 32'h0000_FFFF);
				end
				2: begin
					write_reg(adsr_pkg::CFG_ATTACK_INC, 32'd1);
					write_reg(adsr_pkg::CFG_DECAY_INC, 32'd1);
					write_reg(adsr_pkg::CFG_RELEASE_INC, 32'hFFFF_FFFF);
					write_reg(adsr_pkg::CFG_SUSTAIN, 32'hFFFF_0000);
				end
				4: begin
					// release never advances with a zero step
					write_reg(adsr_pkg::CFG_ATTACK_INC, rand_inc());
					write_reg(adsr_pkg::CFG_DECAY_INC, rand_inc());
					write_reg(adsr_pkg::CFG_RELEASE_INC, 32'd0);
					write_reg(adsr_pkg::CFG_SUSTAIN, $urandom);
				end
				default: begin
					write_reg(adsr_pkg::CFG_ATTACK_INC, rand_inc());
					write_reg(adsr_pkg::CFG_DECAY_INC, rand_inc());
					write_reg(adsr_pkg::CFG_RELEASE_INC, rand_inc());
					write_reg(adsr_pkg::CFG_SUSTAIN, $urandom);
				end
			endcase
			cfg_we <= 1'b0;

			if (ph == 4)
				hold_requests++;

			if (ph == 0) begin
				// rest, then a full note up to sustain
				push_tick(1'b0, 1'b0);
				push_tick(1'b0, 1'b0);
				for (int k = 0; k < 10; k++)
					push_tick(1'b1, 1'b0);
				// trigger rise in sustain restarts attack from the sustain level
				push_tick(1'b1, 1'b1);
				push_tick(1'b1, 1'b1);
				push_tick(1'b1, 1'b0);
				// rise while attack runs is ignored
				push_tick(1'b1, 1'b1);
				// gate fall: release down to rest
				for (int k = 0; k < 5; k++)
					push_tick(1'b0, 1'b0);
				// trigger rise together with gate fall: release wins
				push_tick(1'b1, 1'b0);
				push_tick(1'b0, 1'b1);
				push_tick(1'b0, 1'b0);
				// trigger alone starts a note with the gate low
				push_tick(1'b0, 1'b1);
				push_tick(1'b0, 1'b0);
				push_tick(1'b0, 1'b0);
			end else begin
				queue_random_ticks(PHASE_TICKS);
			end
		end

		while (pending_ticks.size() != 0 || ticks_accepted != ticks_offered
				|| expected_env.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/adsr_pkg.sv
rtl/adsr_tick_if.sv
rtl/adsr_env_if.sv
rtl/adsr_curve_rom.sv
rtl/adsr_stage_ctrl.sv
rtl/adsr_level_calc.sv
rtl/adsr_envelope_generator_unit.sv
test/tb.sv
